@@ rtl/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular double-ended queue.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int VALUE_W    = 32;
    localparam int CAP_W      = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

@@ rtl/cdq_store.sv @@
// ----------------------------------------------------------------------------
// cdq_store
// Single-port entry store with a registered read port.
// ----------------------------------------------------------------------------
module cdq_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_WIDTH-1:0]    i_wdata,
    output logic [DATA_WIDTH-1:0]    o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdq_ctrl
// Head and tail pointers, empty flag, capacity register and result register.
// ----------------------------------------------------------------------------
module cdq_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [cdq_pkg::CAP_W-1:0]         i_cfg_capacity,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [cdq_pkg::OP_W-1:0]          i_operation,
    input  logic signed [cdq_pkg::VALUE_W-1:0] i_push_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [cdq_pkg::STATUS_W-1:0]      o_status,
    output logic signed [cdq_pkg::VALUE_W-1:0] o_pop_value,
    output logic                              o_mem_en,
    output logic                              o_mem_we,
    output logic [$clog2(DEPTH)-1:0]          o_mem_addr,
    output logic [DATA_WIDTH-1:0]             o_mem_wdata,
    input  logic [DATA_WIDTH-1:0]             i_mem_rdata
);
    import cdq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic [CAP_W-1:0] r_capacity;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic             r_vacant, n_vacant;
    logic             r_out_valid;
    t_status          r_status, n_status;
    logic             r_pop_ok, n_pop_ok;

    logic [CAP_W-1:0] cap_eff;
    logic [PTR_W-1:0] cap_last;
    logic             full;
    logic             acc;
    t_op              op;
    logic [63:0]      rdata_wide;

    assign op  = t_op'(i_operation);
    assign acc = i_in_valid && !o_in_stall;

    always_comb begin
        cap_eff = (r_capacity == '0) ? CAP_W'(1) : r_capacity;
        if (32'(cap_eff) > 32'(DEPTH)) begin
            cap_eff = CAP_W'(DEPTH);
        end
    end

    assign cap_last = PTR_W'(cap_eff - CAP_W'(1));

    assign full = !r_vacant &&
                  ((r_head == '0 && r_tail == cap_last) ||
                   ({1'b0, r_head} == {1'b0, r_tail} + (PTR_W+1)'(1)));

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_vacant    = r_vacant;
        n_status    = ST_DONE;
        n_pop_ok    = 1'b0;
        o_mem_en    = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_addr  = r_head;
        o_mem_wdata = DATA_WIDTH'($unsigned(i_push_value));
        if (acc) begin
            unique case (op)
                OP_PUSH_FRONT: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else if (r_vacant) begin
                        n_head     = '0;
                        n_tail     = '0;
                        n_vacant   = 1'b0;
                        o_mem_en   = 1'b1;
                        o_mem_we   = 1'b1;
                        o_mem_addr = '0;
                    end else begin
                        n_head     = (r_head == '0) ? cap_last : r_head - PTR_W'(1);
                        o_mem_en   = 1'b1;
                        o_mem_we   = 1'b1;
                        o_mem_addr = n_head;
                    end
                end
                OP_PUSH_REAR: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else if (r_vacant) begin
                        n_head     = '0;
                        n_tail     = '0;
                        n_vacant   = 1'b0;
                        o_mem_en   = 1'b1;
                        o_mem_we   = 1'b1;
                        o_mem_addr = '0;
                    end else begin
                        n_tail     = (r_tail == cap_last) ? '0 : r_tail + PTR_W'(1);
                        o_mem_en   = 1'b1;
                        o_mem_we   = 1'b1;
                        o_mem_addr = n_tail;
                    end
                end
                OP_POP_FRONT: begin
                    if (r_vacant) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_pop_ok   = 1'b1;
                        o_mem_en   = 1'b1;
                        o_mem_addr = r_head;
                        if (r_head == r_tail) begin
                            n_head   = '0;
                            n_tail   = '0;
                            n_vacant = 1'b1;
                        end else begin
                            n_head = (r_head == cap_last) ? '0 : r_head + PTR_W'(1);
                        end
                    end
                end
                OP_POP_REAR: begin
                    if (r_vacant) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_pop_ok   = 1'b1;
                        o_mem_en   = 1'b1;
                        o_mem_addr = r_tail;
                        if (r_head == r_tail) begin
                            n_head   = '0;
                            n_tail   = '0;
                            n_vacant = 1'b1;
                        end else begin
                            n_tail = (r_tail == '0) ? cap_last : r_tail - PTR_W'(1);
                        end
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_vacant    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_capacity;
                r_head     <= '0;
                r_tail     <= '0;
                r_vacant   <= 1'b1;
            end else begin
                r_head   <= n_head;
                r_tail   <= n_tail;
                r_vacant <= n_vacant;
            end
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result payload until the next transfer in
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    assign rdata_wide  = 64'(i_mem_rdata);
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_pop_value = r_pop_ok ? $signed(rdata_wide[VALUE_W-1:0]) : '0;

    a_vacant_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vacant |-> (r_head == '0 && r_tail == '0))
        else $error("empty queue with pointers away from zero");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vacant |-> (r_head <= cap_last && r_tail <= cap_last))
        else $error("pointer beyond capacity");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_out_valid)
        else $error("accepted item left no result");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !i_cfg_valid && !full &&
         (op == OP_PUSH_FRONT || op == OP_PUSH_REAR)) |=> !r_vacant)
        else $error("successful push left queue empty");

endmodule

@@ rtl/circular_deque.sv @@
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue over a circular single-port store of configurable
// capacity; pushes and pops at either end, refusals reported by status.
//
//   channel   direction  handshake               payload
//   cfg       in         i_cfg_valid/o_cfg_ready i_cfg_capacity
//   in        in         i_in_valid/o_in_stall   i_operation, i_push_value
//   out       out        o_out_valid/i_out_stall o_status, o_pop_value
//
// One item per cycle while the result is not stalled; the result appears in
// the cycle after the transfer in, as the store has a registered read port.
// Reset is synchronous: capacity 16, queue empty; the store is not cleared.
// A capacity write empties the queue.
// A stalled result stalls the input until it is taken.
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]         i_cfg_capacity,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [cdq_pkg::OP_W-1:0]          i_operation,
    input  logic signed [cdq_pkg::VALUE_W-1:0] i_push_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [cdq_pkg::STATUS_W-1:0]      o_status,
    output logic signed [cdq_pkg::VALUE_W-1:0] o_pop_value
);
    import cdq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic                  mem_en;
    logic                  mem_we;
    logic [PTR_W-1:0]      mem_addr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata;

    assign o_cfg_ready = 1'b1;

    cdq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_capacity (i_cfg_capacity),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_push_value   (i_push_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_pop_value    (o_pop_value),
        .o_mem_en       (mem_en),
        .o_mem_we       (mem_we),
        .o_mem_addr     (mem_addr),
        .o_mem_wdata    (mem_wdata),
        .i_mem_rdata    (mem_rdata)
    );

    cdq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule

@@ tb/deque_checker.sv @@
// ----------------------------------------------------------------------------
// deque_checker
// Watches the capacity, operation and result channels of circular_deque,
// keeps its own deque state to work out the status and popped value of every
// operation, and compares each result transfer with the oldest outstanding
// outcome. Hands the mismatch count and the number of outstanding outcomes
// to the bench top.
// ----------------------------------------------------------------------------
module deque_checker #(
    parameter int DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]           i_cfg_capacity,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [cdq_pkg::OP_W-1:0]            i_operation,
    input  logic signed [cdq_pkg::VALUE_W-1:0]  i_push_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [cdq_pkg::STATUS_W-1:0]        i_status,
    input  logic signed [cdq_pkg::VALUE_W-1:0]  i_pop_value,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cdq_pkg::*;

    typedef struct {
        t_status            status;
        logic [VALUE_W-1:0] value;
    } t_outcome;

    logic [VALUE_W-1:0] slots [DEPTH];
    int                 front_ptr;
    int                 back_ptr;
    bit                 drained;
    logic [CAP_W-1:0]   cap_setting;
    t_outcome           outcome_q [$];
    t_outcome           oldest;
    int                 mismatch_total;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        front_ptr    = 0;
        back_ptr     = 0;
        drained      = 1'b1;
        cap_setting  = CAP_RESET;
        mismatch_total = 0;
    end

    function automatic int usable_cap();
        if (cap_setting < 1)
            return 1;
        if (cap_setting > DEPTH)
            return DEPTH;
        return int'(cap_setting);
    endfunction

    function automatic void clear_deque();
        front_ptr = 0;
        back_ptr  = 0;
        drained   = 1'b1;
    endfunction

    function automatic bit deque_full(int cap);
        if (drained)
            return 1'b0;
        return (front_ptr == 0 && back_ptr == cap - 1) || (front_ptr == back_ptr + 1);
    endfunction

    function automatic t_outcome apply_deque_op(t_op op, logic [VALUE_W-1:0] val);
        t_outcome res;
        int       cap;
        cap        = usable_cap();
        res.status = ST_DONE;
        res.value  = '0;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
            if (deque_full(cap)) begin
                res.status = ST_FULL;
            end else if (drained) begin
                front_ptr = 0;
                back_ptr  = 0;
                drained   = 1'b0;
                slots[0]  = val;
            end else if (op == OP_PUSH_FRONT) begin
                front_ptr = (front_ptr == 0) ? cap - 1 : front_ptr - 1;
                slots[front_ptr % DEPTH] = val;
            end else begin
                back_ptr = (back_ptr == cap - 1) ? 0 : back_ptr + 1;
                slots[back_ptr % DEPTH] = val;
            end
        end else begin
            if (drained) begin
                res.status = ST_EMPTY;
            end else if (op == OP_POP_FRONT) begin
                res.value = slots[front_ptr % DEPTH];
                if (front_ptr == back_ptr)
                    clear_deque();
                else
                    front_ptr = (front_ptr == cap - 1) ? 0 : front_ptr + 1;
            end else begin
                res.value = slots[back_ptr % DEPTH];
                if (front_ptr == back_ptr)
                    clear_deque();
                else
                    back_ptr = (back_ptr == 0) ? cap - 1 : back_ptr - 1;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cap_setting = CAP_RESET;
            clear_deque();
            outcome_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (outcome_q.size() == 0) begin
                    $error("unexpected result transfer: status %0d, pop_value %0d",
                           i_status, i_pop_value);
                    mismatch_total++;
                end else begin
                    oldest = outcome_q.pop_front();
                    if (i_status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, i_status);
                        mismatch_total++;
                    end
                    if (i_pop_value !== oldest.value) begin
                        $error("pop_value: expected %0d, actual %0d",
                               $signed(oldest.value), i_pop_value);
                        mismatch_total++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                cap_setting = i_cfg_capacity;
                clear_deque();
            end
            if (i_in_valid && !i_in_stall)
                outcome_q.push_back(apply_deque_op(t_op'(i_operation), i_push_value));
        end
        o_pending    <= outcome_q.size();
        o_fail_count <= mismatch_total;
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus for circular_deque: a directed pass over empty and full refusals,
// both ends, extreme values and out-of-range capacities, then random phases
// of push/pop traffic under several capacities, all but the last with random
// gaps and result stalls. deque_checker checks; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cdq_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 150;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CAP_W-1:0]          cfg_capacity = '0;
    logic                      in_valid     = 1'b0;
    logic                      in_stall;
    logic [OP_W-1:0]           operation    = OP_PUSH_FRONT;
    logic signed [VALUE_W-1:0] push_value   = '0;
    logic                      out_valid;
    logic                      out_stall    = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] pop_value;
    int                        fail_count;
    int                        pending;
    int                        cycle_count  = 0;
    bit                        quiet        = 1'b0;

    always #5ns clk = ~clk;

    circular_deque uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_capacity (cfg_capacity),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (operation),
        .i_push_value   (push_value),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_status       (status),
        .o_pop_value    (pop_value)
    );

    deque_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_capacity (cfg_capacity),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_operation    (operation),
        .i_push_value   (push_value),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_status       (status),
        .i_pop_value    (pop_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("circular_deque test failed");
            $finish;
        end
    end

    initial begin
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(input t_op op, input logic [VALUE_W-1:0] val);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        push_value <= val;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        settle();
        cfg_valid    <= 1'b1;
        cfg_capacity <= cap;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CAP_W-1:0] phase_caps [12];
        int               push_pct;
        t_op              op;

        phase_caps = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd17, 5'd8,
                       5'd0, 5'd5, 5'd2, 5'd15, 5'd4, 5'd16};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(OP_POP_FRONT, 32'h1234_5678);
        send_op(OP_POP_REAR, 32'hFFFF_FFFF);
        send_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_op(OP_PUSH_REAR, 32'h8000_0000);
        send_op(OP_PUSH_FRONT, 32'h0000_0000);
        send_op(OP_PUSH_REAR, 32'hFFFF_FFFF);
        send_op(OP_POP_FRONT, 32'h0);
        send_op(OP_POP_REAR, 32'h0);
        send_op(OP_POP_FRONT, 32'h0);
        send_op(OP_POP_REAR, 32'h0);
        send_op(OP_POP_FRONT, 32'h0);

        set_capacity(5'd1);
        send_op(OP_PUSH_REAR, 32'hA5A5_5A5A);
        send_op(OP_PUSH_FRONT, 32'h5A5A_A5A5);
        send_op(OP_PUSH_REAR, 32'h0F0F_F0F0);
        send_op(OP_POP_REAR, 32'h0);
        send_op(OP_POP_FRONT, 32'h0);

        set_capacity(5'd0);
        send_op(OP_PUSH_FRONT, 32'hDEAD_BEEF);
        send_op(OP_PUSH_REAR, 32'h0000_0001);
        send_op(OP_POP_FRONT, 32'h0);
        send_op(OP_PUSH_REAR, 32'hCAFE_F00D);

        set_capacity(5'd2);
        send_op(OP_POP_REAR, 32'h0);
        send_op(OP_POP_FRONT, 32'h0);

        foreach (phase_caps[p]) begin
            set_capacity(phase_caps[p]);
            if (p == 11)
                quiet = 1'b1;
            push_pct = 50;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 24 == 0)
                    case ($urandom_range(0, 2))
                        0:       push_pct = 15;
                        1:       push_pct = 50;
                        default: push_pct = 85;
                    endcase
                if ($urandom_range(0, 99) < push_pct)
                    op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
                else
                    op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
                send_op(op, random_value());
            end
        end

        settle();
        repeat (5) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("circular_deque test passed");
        else
            $display("circular_deque test failed");
        $finish;
    end

endmodule
